// File: hdl/drt_pkg.sv
// Package for the dirty run tracker: command codes, list capacity and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drt_pkg;
  localparam logic [2:0] CMD_MARK_ALL  = 3'd0;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd1;
  localparam logic [2:0] CMD_SHRINK    = 3'd2;
  localparam logic [2:0] CMD_MARK_RNG  = 3'd3;
  localparam logic [2:0] CMD_MARK_ONE  = 3'd4;
  localparam logic [2:0] CMD_APPEND    = 3'd5;
  localparam logic [2:0] CMD_POP       = 3'd6;
  localparam logic [2:0] CMD_FIND      = 3'd7;

  // list capacity and the 32-bit word memory that holds its marks
  localparam int CAPACITY = 1024;
  localparam int WORDS    = CAPACITY / 32;
  localparam int WAW      = $clog2(WORDS);

  // controller to datapath
  typedef struct packed {
    logic load;   // capture input beat, check it
    logic step;   // one word step of a fill or search
    logic finish; // commit counters and format result
  } drt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk;   // accepted command needs word steps
    logic done;   // last word step taken
  } drt_status_t;
endpackage
`default_nettype wire

// File: hdl/drt_ctrl.sv
// Controller for the dirty run tracker: sequences load, word steps, commit and result.
// Depends on drt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drt_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  output drt_pkg::drt_cmd_t    cmd,
  input  drt_pkg::drt_status_t status
);
  import drt_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_WALK = 3'd2, S_FIN = 3'd3,
                         S_OUT = 3'd4;
  logic [2:0] state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.walk) state_next = S_WALK;
        else state_next = S_FIN;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (status.done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// File: hdl/drt_dp.sv
// Datapath for the dirty run tracker: word-wide mark memory, counters, run search.
// Depends on drt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drt_dp (
  input  wire                   clk,
  input  wire                   rst,
  input  drt_pkg::drt_cmd_t     cmd,
  output drt_pkg::drt_status_t  status,
  input  wire  [2:0]            cmd_code,
  input  wire  [10:0]           position,
  input  wire  [10:0]           count,
  output logic                  found,
  output logic [9:0]            run_start,
  output logic [10:0]           run_length,
  output logic [10:0]           list_length,
  output logic                  changed,
  output logic                  error
);
  import drt_pkg::*;

  // one word of marks per row; bits beyond the length are masked off
  logic [31:0]    mem [WORDS];
  logic [31:0]    rdata;         // registered read of the word under work
  logic [2:0]     op;
  logic [11:0]    lo, hi;        // bit window [lo, hi)
  logic [10:0]    num;           // pop count
  logic [10:0]    ecount;
  logic [11:0]    elen;
  logic           flag;
  logic           err;
  logic           walk;
  logic [WAW-1:0] waddr;         // word under work
  logic           in_run;        // search: a run has started
  logic [11:0]    rb, re;        // search: run start and end

  // decode and check
  logic [11:0]    p, c, psum;
  logic           bad;
  logic [11:0]    win_lo, win_hi;
  logic           need_walk;
  logic [WAW-1:0] saddr;         // first word of the window

  // word step
  logic [11:0]    base, wend;
  logic [31:0]    wmask, ones, zeros, above;
  logic [5:0]     fo, fz, fa;    // first marked, first clear, first clear past fo
  logic           stop;          // search: run ends inside this word
  logic           mem_we;
  logic [31:0]    wdata;
  logic [WAW-1:0] raddr;

  // commit
  logic [10:0]    ecount_next;
  logic           flag_next;
  logic           hit;
  logic [10:0]    run_len;

  assign elen = {1'b0, ecount};
  assign status.walk = walk;
  assign status.done = stop || (wend >= hi);

  // check the beat and set up its bit window
  always_comb begin
    p = {1'b0, position};
    c = {1'b0, count};
    psum = p + c;
    unique case (cmd_code) inside
      CMD_SHRINK, CMD_FIND: bad = p > elen;
      CMD_MARK_RNG:         bad = psum > elen;
      CMD_MARK_ONE:         bad = p >= elen;
      CMD_APPEND:           bad = elen >= 12'(CAPACITY);
      CMD_POP:              bad = c > elen;
      default:              bad = 1'b0;
    endcase
    win_lo = 12'd0;
    win_hi = elen;
    need_walk = 1'b0;
    saddr = '0;
    if (!bad) begin
      unique case (cmd_code) inside
        CMD_MARK_ALL, CMD_CLEAR_ALL: need_walk = elen != 12'd0;
        CMD_SHRINK: win_lo = p;
        CMD_MARK_RNG: begin
          win_lo = p; win_hi = psum; need_walk = c != 12'd0;
          saddr = position[WAW+4:5];
        end
        CMD_MARK_ONE: begin
          win_lo = p; win_hi = p + 12'd1; need_walk = 1'b1;
          saddr = position[WAW+4:5];
        end
        CMD_APPEND: begin
          win_lo = elen; win_hi = elen + 12'd1; need_walk = 1'b1;
          saddr = ecount[WAW+4:5];
        end
        CMD_FIND: begin
          win_lo = p; need_walk = p != elen;
          saddr = position[WAW+4:5];
        end
        default: ;
      endcase
    end
  end

  // masks and first-bit encoders for the current word
  always_comb begin
    base = 12'({waddr, 5'd0});
    wend = base + 12'd32;
    for (int i = 0; i < 32; i++)
      wmask[i] = (base + 12'(i) >= lo) && (base + 12'(i) < hi);
    ones  = rdata & wmask;
    zeros = ~rdata & wmask;
    fo = 6'd32;
    for (int i = 31; i >= 0; i--)
      if (ones[i]) fo = 6'(i);
    fz = 6'd32;
    for (int i = 31; i >= 0; i--)
      if (zeros[i]) fz = 6'(i);
    for (int i = 0; i < 32; i++)
      above[i] = zeros[i] && (6'(i) > fo);
    fa = 6'd32;
    for (int i = 31; i >= 0; i--)
      if (above[i]) fa = 6'(i);
    stop = (op == CMD_FIND) && (in_run ? (fz != 6'd32) : (fa != 6'd32));
  end

  // write back the current word, fetch the next one
  always_comb begin
    mem_we = 1'b0;
    wdata = rdata | wmask;
    if (cmd.step) begin
      unique case (op) inside
        CMD_MARK_ALL, CMD_MARK_RNG, CMD_MARK_ONE, CMD_APPEND: mem_we = 1'b1;
        CMD_CLEAR_ALL: begin
          mem_we = 1'b1;
          wdata = rdata & ~wmask;
        end
        default: ;
      endcase
    end
    raddr = cmd.load ? saddr : waddr + WAW'(1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd.load || cmd.step) rdata <= mem[raddr];
  end

  // counters and flag after the command
  always_comb begin
    ecount_next = ecount;
    flag_next = flag;
    if (!err) begin
      unique case (op) inside
        CMD_MARK_ALL, CMD_MARK_RNG, CMD_MARK_ONE: flag_next = 1'b1;
        CMD_CLEAR_ALL: flag_next = 1'b0;
        CMD_SHRINK: ecount_next = lo[10:0];
        CMD_APPEND: begin
          ecount_next = ecount + 11'd1;
          flag_next = 1'b1;
        end
        CMD_POP: begin
          ecount_next = ecount - num;
          flag_next = 1'b1;
        end
        default: ;
      endcase
    end
    hit = (op == CMD_FIND) && in_run;
    run_len = 11'(re - rb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecount <= '0;
      flag <= 1'b0;
      walk <= 1'b0;
      op <= CMD_MARK_ALL;
      err <= 1'b0;
      num <= '0;
      lo <= '0;
      hi <= '0;
      waddr <= '0;
      in_run <= 1'b0;
      rb <= '0;
      re <= '0;
      found <= 1'b0;
      run_start <= '0;
      run_length <= '0;
      error <= 1'b0;
    end else begin
      // capture the beat
      if (cmd.load) begin
        op <= cmd_code;
        err <= bad;
        num <= count;
        lo <= win_lo;
        hi <= win_hi;
        walk <= need_walk;
        waddr <= saddr;
        in_run <= 1'b0;
        rb <= '0;
        re <= '0;
      end else if (cmd.step) begin
        // advance one word; the search tracks where its run starts and ends
        waddr <= waddr + WAW'(1);
        if (op == CMD_FIND) begin
          if (!in_run) begin
            if (fo != 6'd32) begin
              in_run <= 1'b1;
              rb <= base + 12'(fo);
              re <= (fa != 6'd32) ? base + 12'(fa) : ((wend < hi) ? wend : hi);
            end
          end else begin
            re <= (fz != 6'd32) ? base + 12'(fz) : ((wend < hi) ? wend : hi);
          end
        end
      end
      // commit and hold the result
      if (cmd.finish) begin
        ecount <= ecount_next;
        flag <= flag_next;
        error <= err;
        found <= hit;
        run_start <= hit ? rb[9:0] : 10'd0;
        run_length <= hit ? run_len : 11'd0;
      end
    end
  end

  assign list_length = ecount;
  assign changed = flag;
endmodule
`default_nettype wire

// File: hdl/dirty_run_tracker_top.sv
// Top level of the dirty run tracker: controller plus datapath.
// Depends on drt_pkg, drt_ctrl, drt_dp.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | cmd, position, count
//  out     | out_valid / out_stall| found, run_start, run_length, list_length, changed, error
//
// After a beat is taken: a check state, a word step for each 32-bit mark word that its
// window touches (none for shrink, pop, refused or empty requests; up to 32 for mark
// all, clear all, range or find, and a find stops at the word where its run ends),
// one commit state, then the result. The next beat is taken only once the result of
// the last one has been taken. Reset clears length and flag; the result holds while
// out_stall is high and no new beat is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module dirty_run_tracker_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  cmd,
  input  wire  [10:0] position,
  input  wire  [10:0] count,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        found,
  output logic [9:0]  run_start,
  output logic [10:0] run_length,
  output logic [10:0] list_length,
  output logic        changed,
  output logic        error
);
  import drt_pkg::*;
  drt_cmd_t    c;
  drt_status_t s;

  drt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(c), .status(s)
  );

  drt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(c), .status(s), .cmd_code(cmd),
    .position(position), .count(count), .found(found), .run_start(run_start),
    .run_length(run_length), .list_length(list_length), .changed(changed),
    .error(error)
  );
endmodule
`default_nettype wire

// File: tb/tb_dirty_run_tracker_checker.sv
// Checker for the dirty run tracker: watches both channels, predicts each result
// from its own copy of the mark list, and compares. Depends on drt_pkg.
`timescale 1ns / 1ps
module tb_dirty_run_tracker_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [2:0]  cmd,
  input  wire  [10:0] position,
  input  wire  [10:0] count,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire         found,
  input  wire  [9:0]  run_start,
  input  wire  [10:0] run_length,
  input  wire  [10:0] list_length,
  input  wire         changed,
  input  wire         error,
  output int          fail_count,
  output int          pending
);
  import drt_pkg::*;

  localparam int CAP = 1024;

  typedef struct packed {
    logic        found;
    logic [9:0]  run_start;
    logic [10:0] run_length;
    logic [10:0] list_length;
    logic        changed;
    logic        error;
  } status_t;

  logic    marks [CAP];
  int      len;
  logic    chg;
  status_t expected_status [$];

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one command to the shadow list and return the status it yields.
  function automatic status_t apply_command(input logic [2:0] c, input int p, input int n);
    status_t s;
    int b;
    int e;
    s = '0;
    case (c)
      CMD_MARK_ALL: begin
        for (int i = 0; i < len; i++) marks[i] = 1'b1;
        chg = 1'b1;
      end
      CMD_CLEAR_ALL: begin
        for (int i = 0; i < len; i++) marks[i] = 1'b0;
        chg = 1'b0;
      end
      CMD_SHRINK: begin
        if (p > len) s.error = 1'b1;
        else len = p;
      end
      CMD_MARK_RNG: begin
        if (p + n > len) s.error = 1'b1;
        else begin
          for (int i = p; i < p + n; i++) marks[i] = 1'b1;
          chg = 1'b1;
        end
      end
      CMD_MARK_ONE: begin
        if (p >= len) s.error = 1'b1;
        else begin
          marks[p] = 1'b1;
          chg = 1'b1;
        end
      end
      CMD_APPEND: begin
        if (len >= CAP) s.error = 1'b1;
        else begin
          marks[len] = 1'b1;
          len++;
          chg = 1'b1;
        end
      end
      CMD_POP: begin
        if (n > len) s.error = 1'b1;
        else begin
          len = len - n;
          chg = 1'b1;
        end
      end
      default: begin
        if (p > len) s.error = 1'b1;
        else begin
          b = p;
          while (b < len && !marks[b]) b++;
          e = b;
          while (e < len && marks[e]) e++;
          if (e > b) begin
            s.found = 1'b1;
            s.run_start = b[9:0];
            s.run_length = 11'(e - b);
          end
        end
      end
    endcase
    s.list_length = len[10:0];
    s.changed = chg;
    return s;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    len = 0;
    chg = 1'b0;
    for (int i = 0; i < CAP; i++) marks[i] = 1'b0;
  end

  // Predict on input beats, compare on output beats.
  always @(posedge clk) begin
    status_t w;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_status.push_back(apply_command(cmd, int'(position), int'(count)));
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t unexpected result beat", $time);
          fail_count++;
        end else begin
          w = expected_status.pop_front();
          if (found !== w.found) report("found", int'(found), int'(w.found));
          if (run_start !== w.run_start)
            report("run_start", int'(run_start), int'(w.run_start));
          if (run_length !== w.run_length)
            report("run_length", int'(run_length), int'(w.run_length));
          if (list_length !== w.list_length)
            report("list_length", int'(list_length), int'(w.list_length));
          if (changed !== w.changed) report("changed", int'(changed), int'(w.changed));
          if (error !== w.error) report("error", int'(error), int'(w.error));
        end
      end
      pending <= expected_status.size();
    end
  end
endmodule

// File: tb/tb_dirty_run_tracker_top.sv
// Testbench top for the dirty run tracker: clock, reset, command stimulus and verdict.
// Depends on drt_pkg, dirty_run_tracker_top and tb_dirty_run_tracker_checker.
`timescale 1ns / 1ps
module tb_dirty_run_tracker_top;
  import drt_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = CMD_MARK_ALL;
  logic [10:0] position = '0;
  logic [10:0] count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [9:0]  run_start;
  logic [10:0] run_length;
  logic [10:0] list_length;
  logic        changed;
  logic        error;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          model_len = 0;

  dirty_run_tracker_top dut (.*);

  tb_dirty_run_tracker_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Send one beat, holding it until taken; idle beforehand at the current rate.
  task automatic send(input logic [2:0] c, input int p, input int n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    position <= p[10:0];
    count <= n[10:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // track length roughly to aim random requests at legal windows
    case (c)
      CMD_SHRINK: if (p <= model_len) model_len = p;
      CMD_APPEND: if (model_len < 1024) model_len++;
      CMD_POP: if (n <= model_len) model_len -= n;
      default: ;
    endcase
  endtask

  // Random command, mostly legal, sometimes past the end.
  task automatic send_random();
    logic [2:0] c;
    int p;
    int n;
    c = 3'($urandom_range(7));
    if (model_len < 40 && $urandom_range(3) != 0) c = CMD_APPEND;
    p = (model_len == 0) ? 0 : $urandom_range(model_len);
    n = (p >= model_len) ? 0 : $urandom_range(model_len - p);
    if (c == CMD_POP) n = $urandom_range(model_len < 8 ? model_len : 8);
    if (c == CMD_MARK_RNG && $urandom_range(1)) n = $urandom_range(n < 6 ? n : 6);
    if ($urandom_range(11) == 0) begin
      p = $urandom_range(2047);
      n = $urandom_range(2047);
    end
    send(c, p, n);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty list, fill to capacity, edges and refusals
    send(CMD_FIND, 0, 0);
    send(CMD_POP, 0, 0);
    send(CMD_APPEND, 0, 0);
    send(CMD_MARK_ONE, 1, 0);
    send(CMD_SHRINK, 2, 0);
    send(CMD_CLEAR_ALL, 0, 0);
    for (int i = 0; i < 1023; i++) send(CMD_APPEND, 2047, 2047);
    send(CMD_APPEND, 0, 0);
    send(CMD_FIND, 0, 0);
    send(CMD_CLEAR_ALL, 0, 0);
    send(CMD_MARK_RNG, 0, 0);
    send(CMD_MARK_RNG, 1023, 1);
    send(CMD_MARK_RNG, 1024, 1);
    send(CMD_MARK_ONE, 1024, 0);
    send(CMD_MARK_ONE, 0, 0);
    send(CMD_FIND, 1, 0);
    send(CMD_FIND, 1024, 0);
    send(CMD_FIND, 1025, 0);
    send(CMD_MARK_ALL, 0, 0);
    send(CMD_FIND, 0, 0);
    send(CMD_POP, 1025, 0);
    send(CMD_SHRINK, 1025, 0);
    send(CMD_POP, 1024, 0);
    send(CMD_SHRINK, 0, 2047);
    // random, in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 33 : 0;
      for (int i = 0; i < 250; i++) send_random();
    end
    in_valid <= 1'b0;
    while (pending != 0 || chk.expected_status.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS dirty_run_tracker_top");
    else $display("FAIL dirty_run_tracker_top");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL dirty_run_tracker_top");
    $finish;
  end
endmodule

// File: filelist.f
hdl/drt_pkg.sv
hdl/drt_ctrl.sv
hdl/drt_dp.sv
hdl/dirty_run_tracker_top.sv
tb/tb_dirty_run_tracker_checker.sv
tb/tb_dirty_run_tracker_top.sv
